>>> src/tsdr_pkg.sv
// Package for the text screen refresh block.
// Shared types, character and function codes, command/status structs and
// decimal digit helpers. No dependencies.
package tsdr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] num_t;
  typedef logic [3:0] msg_idx_t;

  localparam int MSG_LEN = 10;

  localparam logic [2:0] FUNC_WRITE   = 3'd0;
  localparam logic [2:0] FUNC_MOVE    = 3'd1;
  localparam logic [2:0] FUNC_CLEAR   = 3'd2;
  localparam logic [2:0] FUNC_REFRESH = 3'd3;
  localparam logic [2:0] FUNC_INIT    = 3'd4;

  localparam byte_t CH_ESC    = 8'd27;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_NL     = 8'd10;
  localparam byte_t CH_BS     = 8'd8;
  localparam byte_t CH_DEL    = 8'd127;
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_H      = 8'h48;
  localparam byte_t CH_QM     = 8'h3F;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_TWO    = 8'h32;
  localparam byte_t CH_FIVE   = 8'h35;
  localparam byte_t CH_L      = 8'h6C;
  localparam byte_t CH_J      = 8'h4A;

  typedef enum logic [1:0] {
    MSG_MOVE,
    MSG_SCAN,
    MSG_RESTORE,
    MSG_INIT
  } msg_sel_e;

  typedef struct packed {
    logic     accept_ok;
    logic     latch_in;
    logic     clr_start;
    logic     wr_fill;
    logic     fill_zero;
    logic     a_inc;
    logic     cur_home;
    logic     cur_nl;
    logic     cur_bs;
    logic     cur_put;
    logic     cur_move;
    logic     scr_start;
    logic     scr_rd;
    logic     scr_wr;
    logic     blank_start;
    logic     scan_rd;
    logic     scan_hit;
    logic     scan_adv;
    logic     scan_wrap;
    logic     msg_load;
    msg_sel_e msg_sel;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       is_nl;
    logic       is_bs;
    logic       col_gt0;
    logic       col_lt;
    logic       row_last;
    logic       top_ok;
    logic       a_last;
    logic       a_copy_last;
    logic       scan_end;
    logic       diff;
    logic       out_free;
    logic       msg_last;
  } dp_status_t;

  // v / 10 by reciprocal, exact for every 7-bit v (v < 128)
  function automatic logic [3:0] tens_of(input num_t v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input num_t v);
    num_t t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

endpackage

>>> src/tsdr_ctrl.sv
// Controller state machine for the text screen refresh block.
// Sequences sweeps, scroll copy, dirty scan and byte emission.
// Depends on tsdr_pkg.
module tsdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tsdr_pkg::dp_status_t st_i,
  output tsdr_pkg::dp_cmd_t    cmd_o
);

  localparam logic [3:0] ST_RST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_FILL     = 4'd3;
  localparam logic [3:0] ST_SCR_RD   = 4'd4;
  localparam logic [3:0] ST_SCR_WR   = 4'd5;
  localparam logic [3:0] ST_BLANK    = 4'd6;
  localparam logic [3:0] ST_SCAN_RD  = 4'd7;
  localparam logic [3:0] ST_SCAN_CMP = 4'd8;
  localparam logic [3:0] ST_EMIT     = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_RST_CLR: begin
        cmd_o.wr_fill   = 1'b1;
        cmd_o.fill_zero = 1'b1;
        cmd_o.a_inc     = 1'b1;
        if (st_i.a_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.accept_ok = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (st_i.func)
          tsdr_pkg::FUNC_WRITE: begin
            state_d = ST_IDLE;
            if (st_i.is_nl) begin
              cmd_o.cur_nl = 1'b1;
              if (st_i.row_last) begin
                if (st_i.top_ok) begin
                  cmd_o.scr_start = 1'b1;
                  state_d = ST_SCR_RD;
                end else begin
                  cmd_o.blank_start = 1'b1;
                  state_d = ST_BLANK;
                end
              end
            end else if (st_i.is_bs) begin
              cmd_o.cur_bs = st_i.col_gt0;
            end else begin
              cmd_o.cur_put = st_i.col_lt;
            end
          end
          tsdr_pkg::FUNC_MOVE: begin
            cmd_o.cur_move = 1'b1;
            cmd_o.msg_load = 1'b1;
            cmd_o.msg_sel  = tsdr_pkg::MSG_MOVE;
            state_d = ST_EMIT;
          end
          tsdr_pkg::FUNC_CLEAR, tsdr_pkg::FUNC_INIT: begin
            cmd_o.clr_start = 1'b1;
            cmd_o.cur_home  = 1'b1;
            state_d = ST_FILL;
          end
          tsdr_pkg::FUNC_REFRESH: state_d = ST_SCAN_RD;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.a_inc   = 1'b1;
        if (st_i.a_last) begin
          if (st_i.func == tsdr_pkg::FUNC_INIT) begin
            cmd_o.msg_load = 1'b1;
            cmd_o.msg_sel  = tsdr_pkg::MSG_INIT;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCR_RD: begin
        cmd_o.scr_rd = 1'b1;
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd_o.scr_wr = 1'b1;
        cmd_o.a_inc  = 1'b1;
        if (st_i.a_copy_last) begin
          cmd_o.blank_start = 1'b1;
          state_d = ST_BLANK;
        end else begin
          state_d = ST_SCR_RD;
        end
      end
      ST_BLANK: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.a_inc   = 1'b1;
        if (st_i.a_last) state_d = ST_IDLE;
      end
      ST_SCAN_RD: begin
        if (st_i.scan_end) begin
          cmd_o.scan_wrap = 1'b1;
          cmd_o.msg_load  = 1'b1;
          cmd_o.msg_sel   = tsdr_pkg::MSG_RESTORE;
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (st_i.diff) begin
          cmd_o.scan_hit = 1'b1;
          cmd_o.msg_load = 1'b1;
          cmd_o.msg_sel  = tsdr_pkg::MSG_SCAN;
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (st_i.out_free && st_i.msg_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_RST_CLR;
    else         state_q <= state_d;
  end

endmodule

>>> src/tsdr_dp.sv
// Datapath for the text screen refresh block: both cell stores, cursor,
// scan position, escape sequence buffer and output register.
// Depends on tsdr_pkg.
module tsdr_dp #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsdr_pkg::dp_cmd_t    cmd_i,
  output tsdr_pkg::dp_status_t st_o,
  input  logic [2:0]           func_i,
  input  logic [7:0]           char_code_i,
  input  logic [6:0]           target_col_i,
  input  logic [5:0]           target_row_i,
  input  logic                 cfg_we_i,
  input  logic [5:0]           scroll_top_row_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           tx_byte_o,
  output logic                 last_of_run_o,
  output logic                 refresh_done_o
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(SCREEN_COLS + 1);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int SC_W  = $clog2(SCREEN_COLS);

  tsdr_pkg::byte_t wmem [CELLS];
  tsdr_pkg::byte_t smem [CELLS];

  logic [2:0]       func_q;
  tsdr_pkg::byte_t  char_q;
  logic [6:0]       tcol_q;
  logic [5:0]       trow_q;
  logic [5:0]       top_q;
  logic [COL_W-1:0] cur_col_q;
  logic [ROW_W-1:0] cur_row_q;
  logic [AW-1:0]    a_q;
  logic [PW-1:0]    scan_pos_q;
  logic [ROW_W-1:0] scan_r_q;
  logic [SC_W-1:0]  scan_c_q;
  tsdr_pkg::byte_t  rd_w_q, rd_s_q;

  tsdr_pkg::byte_t    msg_q [tsdr_pkg::MSG_LEN];
  tsdr_pkg::msg_idx_t len_q, k_q;
  logic               done_q;

  logic                out_valid_q, last_q, rdone_q;
  tsdr_pkg::byte_t     tx_q;

  logic [COL_W-1:0] sat_col;
  logic [ROW_W-1:0] sat_row;
  logic [AW-1:0]    cur_base, cur_addr, rd_addr, ww_addr;
  logic             ww_en;
  tsdr_pkg::byte_t  ww_data;
  logic             out_free;

  assign sat_col = (int'(tcol_q) > SCREEN_COLS - 1) ? COL_W'(SCREEN_COLS - 1) : COL_W'(tcol_q);
  assign sat_row = (int'(trow_q) > SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(trow_q);

  assign cur_base = AW'(int'(cur_row_q) * SCREEN_COLS);
  assign cur_addr = cmd_i.cur_bs ? AW'(int'(cur_base) + int'(cur_col_q) - 1)
                                 : AW'(int'(cur_base) + int'(cur_col_q));
  assign rd_addr  = cmd_i.scan_rd ? scan_pos_q[AW-1:0] : AW'(int'(a_q) + SCREEN_COLS);

  always_comb begin
    ww_en   = 1'b0;
    ww_addr = a_q;
    ww_data = tsdr_pkg::CH_SPACE;
    if (cmd_i.wr_fill) begin
      ww_en   = 1'b1;
      ww_data = cmd_i.fill_zero ? '0 : tsdr_pkg::CH_SPACE;
    end else if (cmd_i.scr_wr) begin
      ww_en   = 1'b1;
      ww_data = rd_w_q;
    end else if (cmd_i.cur_bs) begin
      ww_en   = 1'b1;
      ww_addr = cur_addr;
    end else if (cmd_i.cur_put) begin
      ww_en   = 1'b1;
      ww_addr = cur_addr;
      ww_data = char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ww_en) wmem[ww_addr] <= ww_data;
    if (cmd_i.wr_fill && cmd_i.fill_zero) smem[a_q] <= '0;
    else if (cmd_i.scan_hit) smem[scan_pos_q[AW-1:0]] <= rd_w_q;
    rd_w_q <= wmem[rd_addr];
    rd_s_q <= smem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_i;
      char_q <= char_code_i;
      tcol_q <= target_col_i;
      trow_q <= target_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q      <= 6'd21;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      a_q        <= '0;
      scan_pos_q <= '0;
      scan_r_q   <= '0;
      scan_c_q   <= '0;
    end else begin
      if (cfg_we_i) top_q <= scroll_top_row_i;
      if (cmd_i.clr_start) a_q <= '0;
      else if (cmd_i.scr_start) a_q <= AW'(int'(top_q) * SCREEN_COLS);
      else if (cmd_i.blank_start) a_q <= AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
      else if (cmd_i.a_inc) a_q <= a_q + 1'b1;

      if (cmd_i.cur_home) begin
        cur_col_q <= '0;
        cur_row_q <= '0;
      end else if (cmd_i.cur_nl) begin
        cur_col_q <= '0;
        if (!st_o.row_last) cur_row_q <= cur_row_q + 1'b1;
      end else if (cmd_i.cur_bs) begin
        cur_col_q <= cur_col_q - 1'b1;
      end else if (cmd_i.cur_put) begin
        cur_col_q <= cur_col_q + 1'b1;
      end else if (cmd_i.cur_move) begin
        cur_col_q <= sat_col;
        cur_row_q <= sat_row;
      end

      if (cmd_i.cur_home || cmd_i.scan_wrap) begin
        scan_pos_q <= '0;
        scan_r_q   <= '0;
        scan_c_q   <= '0;
      end else if (cmd_i.scan_hit || cmd_i.scan_adv) begin
        scan_pos_q <= scan_pos_q + 1'b1;
        if (int'(scan_c_q) == SCREEN_COLS - 1) begin
          scan_c_q <= '0;
          scan_r_q <= scan_r_q + 1'b1;
        end else begin
          scan_c_q <= scan_c_q + 1'b1;
        end
      end
    end
  end

  // escape sequence assembly
  tsdr_pkg::byte_t    m [tsdr_pkg::MSG_LEN];
  tsdr_pkg::msg_idx_t n;
  tsdr_pkg::num_t     na, nb;
  logic               with_ch, dn;

  always_comb begin
    for (int i = 0; i < tsdr_pkg::MSG_LEN; i++) m[i] = '0;
    n       = '0;
    with_ch = 1'b0;
    dn      = 1'b0;
    na      = tsdr_pkg::num_t'(sat_row);
    nb      = tsdr_pkg::num_t'(sat_col);
    case (cmd_i.msg_sel)
      tsdr_pkg::MSG_SCAN: begin
        na      = tsdr_pkg::num_t'(scan_r_q) + 7'd1;
        nb      = tsdr_pkg::num_t'(scan_c_q) + 7'd1;
        with_ch = 1'b1;
      end
      tsdr_pkg::MSG_RESTORE: begin
        na = tsdr_pkg::num_t'(cur_row_q);
        nb = tsdr_pkg::num_t'(cur_col_q);
        dn = 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.msg_sel == tsdr_pkg::MSG_INIT) begin
      m[0] = tsdr_pkg::CH_ESC;  m[1] = tsdr_pkg::CH_LBRACK;
      m[2] = tsdr_pkg::CH_QM;   m[3] = tsdr_pkg::CH_TWO;
      m[4] = tsdr_pkg::CH_FIVE; m[5] = tsdr_pkg::CH_L;
      m[6] = tsdr_pkg::CH_ESC;  m[7] = tsdr_pkg::CH_LBRACK;
      m[8] = tsdr_pkg::CH_TWO;  m[9] = tsdr_pkg::CH_J;
      n = 4'd10;
    end else begin
      m[n] = tsdr_pkg::CH_ESC;    n = n + 4'd1;
      m[n] = tsdr_pkg::CH_LBRACK; n = n + 4'd1;
      if (na >= 7'd10) begin
        m[n] = tsdr_pkg::CH_ZERO + 8'(tsdr_pkg::tens_of(na)); n = n + 4'd1;
      end
      m[n] = tsdr_pkg::CH_ZERO + 8'(tsdr_pkg::ones_of(na)); n = n + 4'd1;
      m[n] = tsdr_pkg::CH_SEMI; n = n + 4'd1;
      if (nb >= 7'd10) begin
        m[n] = tsdr_pkg::CH_ZERO + 8'(tsdr_pkg::tens_of(nb)); n = n + 4'd1;
      end
      m[n] = tsdr_pkg::CH_ZERO + 8'(tsdr_pkg::ones_of(nb)); n = n + 4'd1;
      m[n] = tsdr_pkg::CH_H; n = n + 4'd1;
      if (with_ch) begin
        m[n] = rd_w_q; n = n + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.msg_load) msg_q <= m;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      k_q         <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      tx_q        <= '0;
      last_q      <= 1'b0;
      rdone_q     <= 1'b0;
    end else begin
      if (cmd_i.msg_load) begin
        len_q  <= n;
        k_q    <= '0;
        done_q <= dn;
      end else if (cmd_i.emit && out_free) begin
        k_q <= k_q + 4'd1;
      end
      if (cmd_i.emit && out_free) begin
        out_valid_q <= 1'b1;
        tx_q        <= msg_q[k_q];
        last_q      <= st_o.msg_last;
        rdone_q     <= st_o.msg_last && done_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_byte_o      = tx_q;
  assign last_of_run_o  = last_q;
  assign refresh_done_o = rdone_q;

  always_comb begin
    st_o             = '0;
    st_o.func        = func_q;
    st_o.is_nl       = (char_q == tsdr_pkg::CH_NL);
    st_o.is_bs       = (char_q == tsdr_pkg::CH_BS) || (char_q == tsdr_pkg::CH_DEL);
    st_o.col_gt0     = (cur_col_q != '0);
    st_o.col_lt      = (int'(cur_col_q) < SCREEN_COLS);
    st_o.row_last    = (int'(cur_row_q) == SCREEN_ROWS - 1);
    st_o.top_ok      = (int'(top_q) < SCREEN_ROWS - 1);
    st_o.a_last      = (int'(a_q) == CELLS - 1);
    st_o.a_copy_last = (int'(a_q) == (SCREEN_ROWS - 1) * SCREEN_COLS - 1);
    st_o.scan_end    = (int'(scan_pos_q) == CELLS);
    st_o.diff        = (rd_w_q != rd_s_q);
    st_o.out_free    = out_free;
    st_o.msg_last    = (k_q == len_q - 4'd1);
  end

endmodule

>>> src/text_screen_diff_refresh.sv
// Bytes: move emits 6-8 bytes and init 10, at one per cycle when unstalled.
// Clear/init sweep every cell; scroll copies the rows below the top row up by one
// and blanks the last row; a refresh step emits the bytes of the next differing cell.
// Throughput is bound by one item at a time, the store ports and the byte stream.
// Reset: asynchronous active low; both stores are then zeroed by a sweep over
// every cell, during which no item is accepted.
module text_screen_diff_refresh #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 50
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] target_col_i,
  input  logic [5:0] target_row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_of_run_o,
  output logic       refresh_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] scroll_top_row_i
);

  tsdr_pkg::dp_cmd_t    cmd;
  tsdr_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !cmd.accept_ok;

  tsdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tsdr_dp #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .func_i           (func_i),
    .char_code_i      (char_code_i),
    .target_col_i     (target_col_i),
    .target_row_i     (target_row_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .scroll_top_row_i (scroll_top_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tx_byte_o        (tx_byte_o),
    .last_of_run_o    (last_of_run_o),
    .refresh_done_o   (refresh_done_o)
  );

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && refresh_done_o |-> last_of_run_o)
    else $error("refresh_done without last_of_run");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");
`endif

endmodule
